@@ rtl/tbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpf_pkg
// Types, constants and helpers shared by the background pixel fetch block.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  // video memory layout
  localparam int VRAM_BYTES  = 8192;
  localparam int VRAM_AW     = $clog2(VRAM_BYTES);
  localparam int MAP_ENTRIES = 1024;
  localparam int MAP_AW      = $clog2(MAP_ENTRIES);
  localparam logic [VRAM_AW-1:0] MAP_BASE = 13'h1800;
  // tile data lives below the map, two plane bytes to a word
  localparam int TILE_WORDS  = 3072;
  localparam int TILE_AW     = $clog2(TILE_WORDS);
  localparam logic [TILE_AW-1:0] LOW_TILE_WORD = 12'h400;
  localparam logic [7:0] LOW_TILE_BIAS = 8'h80;

  // lcd_control bits
  localparam int CTRL_DISPLAY_BIT  = 7;
  localparam int CTRL_UNSIGNED_BIT = 4;
  localparam int CTRL_BG_BIT       = 0;

  localparam logic [7:0] SHADE_WHITE = 8'hFF;
  localparam logic [7:0] SHADE_LIGHT = 8'h80;
  localparam logic [7:0] SHADE_DARK  = 8'h60;
  localparam logic [7:0] SHADE_DEEP  = 8'h20;
  localparam logic [7:0] SHADE_BLACK = 8'h00;

  typedef enum logic [1:0] {
    REG_LCD_CONTROL,
    REG_SCROLL_Y,
    REG_SCROLL_X,
    REG_BG_PALETTE
  } reg_index_t;

  typedef enum logic {
    FUNC_WRITE,
    FUNC_RENDER
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [VRAM_AW-1:0] mem_address;
    logic [7:0]         mem_data;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
  } cmd_t;

  typedef struct packed {
    logic       drawn;
    logic [1:0] colour_index;
    logic [7:0] shade;
  } pix_t;

  typedef struct packed {
    logic               en;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
  } vram_wr_t;

  function automatic logic [7:0] grey_level(input logic [1:0] sel);
    logic [7:0] g;
    unique case (sel)
      2'd0: g = SHADE_WHITE;
      2'd1: g = SHADE_LIGHT;
      2'd2: g = SHADE_DARK;
      2'd3: g = SHADE_DEEP;
      default: g = SHADE_BLACK;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/tbpf_vram.sv @@
// ----------------------------------------------------------------------------
// tbpf_vram
// Video memory split into a tile map bank and a tile data bank of plane pairs.
// ----------------------------------------------------------------------------
module tbpf_vram (
  input  logic                      clk,
  input  tbpf_pkg::vram_wr_t        wr,
  input  logic                      map_rd_en,
  input  logic [tbpf_pkg::MAP_AW-1:0]  map_rd_addr,
  output logic [7:0]                map_q,
  input  logic                      tile_rd_en,
  input  logic [tbpf_pkg::TILE_AW-1:0] tile_rd_addr,
  output logic [15:0]               tile_q
);
  import tbpf_pkg::*;

  logic [7:0]      map_mem  [MAP_ENTRIES];
  logic [1:0][7:0] tile_mem [TILE_WORDS];

  logic map_we;
  logic tile_we;

  // map covers 0x1800..0x1BFF; bytes above it are never read, so drop them
  assign map_we  = wr.en && (wr.addr[VRAM_AW-1:MAP_AW] == MAP_BASE[VRAM_AW-1:MAP_AW]);
  assign tile_we = wr.en && (wr.addr < MAP_BASE);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[wr.addr[MAP_AW-1:0]] <= wr.data;
    end
    if (map_rd_en) begin
      map_q <= map_mem[map_rd_addr];
    end
  end

  // even byte is the low plane, odd byte the high plane
  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[wr.addr[TILE_AW:1]][wr.addr[0]] <= wr.data;
    end
    if (tile_rd_en) begin
      tile_q <= tile_mem[tile_rd_addr];
    end
  end

endmodule

@@ rtl/tile_background_pixel_fetch.sv @@
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch
// Each render word yields a pixel word after the map read and the plane read.
// Throughput: one word per cycle unless the receiver stalls; the map read and
// the plane read are two memory stages in a row.
// Reset: synchronous; clears config registers and pipe valids, video memory holds.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  tbpf_pkg::cmd_t       cmd,
  output logic                 pix_valid,
  input  logic                 pix_stall,
  output tbpf_pkg::pix_t       pix,
  input  logic                 cfg_we,
  input  tbpf_pkg::reg_index_t cfg_index,
  input  logic [7:0]           cfg_data
);
  import tbpf_pkg::*;

  logic [7:0] lcd_control;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] bg_palette;

  logic adv_out;
  logic adv_s1;
  logic cmd_acc;
  logic render_acc;
  logic [7:0] px;
  logic [7:0] py;

  logic       s1_valid;
  logic [2:0] s1_row;
  logic [2:0] s1_col;
  logic [2:0] out_col;

  vram_wr_t           wr;
  logic [7:0]         map_q;
  logic [15:0]        tile_q;
  logic               tile_rd_en;
  logic [7:0]         tile_sel;
  logic [TILE_AW-1:0] tile_word;

  logic [1:0] colour;
  logic [1:0] sel;
  logic       enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= '0;
      scroll_y    <= '0;
      scroll_x    <= '0;
      bg_palette  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LCD_CONTROL: lcd_control <= cfg_data;
        REG_SCROLL_Y:    scroll_y    <= cfg_data;
        REG_SCROLL_X:    scroll_x    <= cfg_data;
        REG_BG_PALETTE:  bg_palette  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage moves when empty or when the stage after it moves; a write behind a
  // staged render is taken only on the edge of its plane read, so that read sees old data
  assign adv_out    = !pix_valid || !pix_stall;
  assign adv_s1     = !s1_valid || adv_out;
  assign cmd_stall  = rst || !adv_s1;
  assign cmd_acc    = cmd_valid && !cmd_stall;
  assign render_acc = cmd_acc && (cmd.func == FUNC_RENDER);

  assign px = cmd.pos_x + scroll_x;
  assign py = cmd.pos_y + scroll_y;

  assign wr.en   = cmd_acc && (cmd.func == FUNC_WRITE);
  assign wr.addr = cmd.mem_address;
  assign wr.data = cmd.mem_data;

  // offset addressing: tile n at 0x800 + 16*((n+128) mod 256)
  assign tile_sel  = lcd_control[CTRL_UNSIGNED_BIT] ? map_q : (map_q ^ LOW_TILE_BIAS);
  assign tile_word = {1'b0, tile_sel, s1_row}
                   + (lcd_control[CTRL_UNSIGNED_BIT] ? '0 : LOW_TILE_WORD);
  assign tile_rd_en = s1_valid && adv_out;

  tbpf_vram u_vram (
    .clk          (clk),
    .wr           (wr),
    .map_rd_en    (render_acc),
    .map_rd_addr  ({py[7:3], px[7:3]}),
    .map_q        (map_q),
    .tile_rd_en   (tile_rd_en),
    .tile_rd_addr (tile_word),
    .tile_q       (tile_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= render_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (render_acc) begin
      s1_row <= py[2:0];
      s1_col <= px[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (adv_out) begin
      pix_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tile_rd_en) begin
      out_col <= s1_col;
    end
  end

  // leftmost pixel is bit 7 of each plane
  assign colour  = {tile_q[{1'b1, ~out_col}], tile_q[{1'b0, ~out_col}]};
  assign sel     = bg_palette[{colour, 1'b0} +: 2];
  assign enabled = lcd_control[CTRL_DISPLAY_BIT] && lcd_control[CTRL_BG_BIT];

  always_comb begin
    if (enabled) begin
      pix.drawn        = 1'b1;
      pix.colour_index = colour;
      pix.shade        = grey_level(sel);
    end else begin
      pix.drawn        = 1'b0;
      pix.colour_index = 2'd0;
      pix.shade        = SHADE_BLACK;
    end
  end

endmodule

@@ rtl/tbpf_checker.sv @@
// ----------------------------------------------------------------------------
// tbpf_checker
// Port-level checks on the background pixel fetch block, bound to the top.
// ----------------------------------------------------------------------------
module tbpf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_stall,
  input tbpf_pkg::cmd_t       cmd,
  input logic                 pix_valid,
  input logic                 pix_stall,
  input tbpf_pkg::pix_t       pix
);
  import tbpf_pkg::*;

  logic render_acc;

  assign render_acc = cmd_valid && !cmd_stall && (cmd.func == FUNC_RENDER);

  // a stalled pixel word holds
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("pixel word changed while stalled");

  // a fresh pixel word comes from a render taken before its map read and plane read
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(render_acc, 2))
    else $error("pixel word without matching render");

  // input backs up only behind a waiting pixel word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> pix_valid)
    else $error("input stalled with empty output");

  // shade agrees with drawn and the grey set
  a_shade: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> (pix.drawn ?
      (pix.shade == SHADE_WHITE || pix.shade == SHADE_LIGHT ||
       pix.shade == SHADE_DARK  || pix.shade == SHADE_DEEP) :
      (pix.shade == SHADE_BLACK && pix.colour_index == 2'd0)))
    else $error("shade out of set");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (.*);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: background pixel fetch testbench
// Writes video memory where a render will read it and at random, then runs directed
// words (reset state, write-to-render forwarding, both tile addressing modes,
// scroll wrap, display and background off) and random phases of tile rows and
// noise under several register settings. A predictor tracks video memory and
// registers at the handshake, and each pixel word is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbpf_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 130;
  localparam int ROW_WORDS     = 11;
  localparam logic [VRAM_AW-1:0] LOW_TILE_ADDR = 13'h0800;
  localparam logic [7:0] GREY [4] = '{SHADE_WHITE, SHADE_LIGHT, SHADE_DARK, SHADE_DEEP};

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  cmd_t       cmd;
  logic       pix_valid;
  logic       pix_stall;
  pix_t       pix;
  logic       cfg_we;
  reg_index_t cfg_index;
  logic [7:0] cfg_data;

  // predictor state
  logic [7:0] vram_copy [VRAM_BYTES];
  bit         vram_written [VRAM_BYTES];
  logic [7:0] lcd_ctrl_q = '0;
  logic [7:0] scroll_y_q = '0;
  logic [7:0] scroll_x_q = '0;
  logic [7:0] palette_q  = '0;
  pix_t       pixel_expect_q [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  tile_background_pixel_fetch dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [VRAM_AW-1:0] plane_address(input logic [7:0] tile_no,
                                                        input logic [2:0] row);
    logic [VRAM_AW-1:0] base;
    logic [7:0]         t;
    if (lcd_ctrl_q[CTRL_UNSIGNED_BIT]) begin
      base = '0;
      t    = tile_no;
    end else begin
      base = LOW_TILE_ADDR;
      t    = tile_no + LOW_TILE_BIAS;
    end
    return base + {t, 4'b0000} + {row, 1'b0};
  endfunction

  function automatic pix_t predict_pixel(input cmd_t c);
    pix_t               p;
    logic [7:0]         px;
    logic [7:0]         py;
    logic [7:0]         tile_no;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [VRAM_AW-1:0] a;
    logic [2:0]         bit_pos;
    logic [1:0]         colour;
    logic [1:0]         sel;
    p       = '0;
    p.shade = SHADE_BLACK;
    if (!lcd_ctrl_q[CTRL_DISPLAY_BIT] || !lcd_ctrl_q[CTRL_BG_BIT]) return p;
    px      = c.pos_x + scroll_x_q;
    py      = c.pos_y + scroll_y_q;
    tile_no = vram_copy[MAP_BASE + {py[7:3], px[7:3]}];
    a       = plane_address(tile_no, py[2:0]);
    lo      = vram_copy[a];
    hi      = vram_copy[a + 1'b1];
    bit_pos = 3'd7 - px[2:0];
    colour  = {hi[bit_pos], lo[bit_pos]};
    sel     = palette_q[{colour, 1'b0} +: 2];
    p.drawn        = 1'b1;
    p.colour_index = colour;
    p.shade        = GREY[sel];
    return p;
  endfunction

  // true when every byte the render reads has been written
  function automatic bit render_safe(input logic [7:0] x, input logic [7:0] y);
    logic [7:0]         px;
    logic [7:0]         py;
    logic [VRAM_AW-1:0] m;
    logic [VRAM_AW-1:0] a;
    if (!lcd_ctrl_q[CTRL_DISPLAY_BIT] || !lcd_ctrl_q[CTRL_BG_BIT]) return 1'b1;
    px = x + scroll_x_q;
    py = y + scroll_y_q;
    m  = MAP_BASE + {py[7:3], px[7:3]};
    if (!vram_written[m]) return 1'b0;
    a  = plane_address(vram_copy[m], py[2:0]);
    return vram_written[a] && vram_written[a + 1'b1];
  endfunction

  task automatic report_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
    mismatches++;
    $display("%0t ns: %s expected %h got %h", $time, field, want_v, got_v);
  endtask

  // track registers at the handshake, check pixel words in order
  always @(posedge clk) begin
    pix_t want;
    if (!rst && cfg_we) begin
      case (cfg_index)
        REG_LCD_CONTROL: lcd_ctrl_q = cfg_data;
        REG_SCROLL_Y:    scroll_y_q = cfg_data;
        REG_SCROLL_X:    scroll_x_q = cfg_data;
        REG_BG_PALETTE:  palette_q  = cfg_data;
        default: ;
      endcase
    end
    if (!rst && cmd_valid && !cmd_stall && cmd.func == FUNC_RENDER)
      pixel_expect_q.push_back(predict_pixel(cmd));
    if (!rst && pix_valid && !pix_stall) begin
      if (pixel_expect_q.size() == 0) begin
        report_field("unexpected pixel word, shade", 8'h00, pix.shade);
      end else begin
        want = pixel_expect_q.pop_front();
        if (pix.drawn !== want.drawn)
          report_field("drawn", {7'b0, want.drawn}, {7'b0, pix.drawn});
        if (pix.colour_index !== want.colour_index)
          report_field("colour_index", {6'b0, want.colour_index}, {6'b0, pix.colour_index});
        if (pix.shade !== want.shade)
          report_field("shade", want.shade, pix.shade);
      end
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    logic hold;
    if (stall_left > 0) begin
      hold = 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      hold       = 1'b1;
      stall_left = $urandom_range(18, 0);
    end else begin
      hold = 1'b0;
    end
    pix_stall <= hold;
  end

  function automatic cmd_t make_write(input logic [VRAM_AW-1:0] addr, input logic [7:0] data);
    cmd_t w;
    w.func        = FUNC_WRITE;
    w.mem_address = addr;
    w.mem_data    = data;
    w.pos_x       = 8'($urandom_range(255));
    w.pos_y       = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic cmd_t make_render(input logic [7:0] x, input logic [7:0] y);
    cmd_t w;
    w.func        = FUNC_RENDER;
    w.mem_address = 13'($urandom_range(VRAM_BYTES - 1));
    w.mem_data    = 8'($urandom_range(255));
    w.pos_x       = x;
    w.pos_y       = y;
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_word(input cmd_t w);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(19, 1) : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (cmd_stall);
    // the write is taken on this edge; later words see it
    if (w.func == FUNC_WRITE) begin
      vram_copy[w.mem_address]    = w.mem_data;
      vram_written[w.mem_address] = 1'b1;
    end
  endtask

  // hold off the sender until every pixel word is back
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] lcd, input logic [7:0] sy,
                            input logic [7:0] sx, input logic [7:0] pal);
    wait_idle();
    write_reg(REG_LCD_CONTROL, lcd);
    write_reg(REG_SCROLL_Y, sy);
    write_reg(REG_SCROLL_X, sx);
    write_reg(REG_BG_PALETTE, pal);
  endtask

  // map entry and both planes under one pixel, then the pixel itself
  task automatic fill_and_render(input logic [7:0] x, input logic [7:0] y);
    logic [7:0]         px;
    logic [7:0]         py;
    logic [7:0]         tile_no;
    logic [VRAM_AW-1:0] a;
    px      = x + scroll_x_q;
    py      = y + scroll_y_q;
    tile_no = 8'($urandom_range(255));
    send_word(make_write(MAP_BASE + {py[7:3], px[7:3]}, tile_no));
    a = plane_address(tile_no, py[2:0]);
    send_word(make_write(a, 8'($urandom_range(255))));
    send_word(make_write(a + 1'b1, 8'($urandom_range(255))));
    send_word(make_render(x, y));
  endtask

  // map entry and both planes of one tile row, then all eight pixels of it
  task automatic tile_row();
    logic [4:0]         col;
    logic [7:0]         py;
    logic [7:0]         tile_no;
    logic [VRAM_AW-1:0] a;
    col     = 5'($urandom_range(31));
    py      = 8'($urandom_range(255));
    tile_no = 8'($urandom_range(255));
    send_word(make_write(MAP_BASE + {py[7:3], col}, tile_no));
    a = plane_address(tile_no, py[2:0]);
    send_word(make_write(a, 8'($urandom_range(255))));
    send_word(make_write(a + 1'b1, 8'($urandom_range(255))));
    for (int i = 0; i < 8; i++)
      send_word(make_render({col, 3'(i)} - scroll_x_q, py - scroll_y_q));
  endtask

  task automatic test_reset_state();
    send_word(make_render(8'h00, 8'h00));
    send_word(make_render(8'hFF, 8'hFF));
  endtask

  // renders right behind the writes they read
  task automatic test_forwarding();
    set_config(8'h91, 8'h00, 8'h00, 8'hE4);
    send_word(make_write(MAP_BASE, 8'h00));
    send_word(make_write(13'h0000, 8'h55));
    send_word(make_write(13'h0001, 8'h33));
    for (int x = 0; x < 4; x++) send_word(make_render(8'(x), 8'h00));
  endtask

  task automatic test_tile_addressing();
    set_config(8'h81, 8'h00, 8'h00, 8'hE4);
    // offset tile numbers: 0x80 lands at the low tile base, 0x7F at its top
    send_word(make_write(MAP_BASE, 8'h80));
    send_word(make_write(LOW_TILE_ADDR, 8'hFF));
    send_word(make_write(LOW_TILE_ADDR + 13'h1, 8'h00));
    send_word(make_render(8'h00, 8'h00));
    send_word(make_write(MAP_BASE, 8'h7F));
    send_word(make_write(13'h17F0, 8'h00));
    send_word(make_write(13'h17F1, 8'hFF));
    send_word(make_render(8'h07, 8'h00));
    set_config(8'h91, 8'h00, 8'h00, 8'hE4);
    fill_and_render(8'd159, 8'd143);
    fill_and_render(8'hFF, 8'hFF);
  endtask

  task automatic test_scroll_wrap();
    set_config(8'h91, 8'hFF, 8'hFF, 8'h1B);
    fill_and_render(8'h00, 8'h00);
    fill_and_render(8'h01, 8'h01);
    fill_and_render(8'hFF, 8'hFF);
  endtask

  task automatic test_lcd_modes();
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    send_word(make_render(8'h10, 8'h10));
    set_config(8'h80, 8'h12, 8'h34, 8'hE4);
    send_word(make_render(8'h10, 8'h10));
    set_config(8'h7F, 8'h12, 8'h34, 8'hE4);
    send_word(make_render(8'h10, 8'h10));
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    fill_and_render(8'h10, 8'h10);
  endtask

  task automatic test_random_traffic(input int phases, input bit quiet);
    int         sent;
    int         lcd_pick;
    logic [7:0] rx;
    logic [7:0] ry;
    for (int ph = 0; ph < phases; ph++) begin
      lcd_pick = $urandom_range(9);
      set_config((lcd_pick < 7) ? (8'($urandom_range(255)) | 8'h81) : pick_byte(),
                 pick_byte(), pick_byte(), pick_byte());
      if (quiet) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = $urandom_range(2) * 15;
        stall_pct = $urandom_range(2) * 15;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(9) < 7) begin
          tile_row();
          sent += ROW_WORDS;
        end else if ($urandom_range(1) == 0) begin
          send_word(make_write(13'($urandom_range(VRAM_BYTES - 1)),
                               8'($urandom_range(255))));
          sent++;
        end else begin
          rx = 8'($urandom_range(255));
          ry = 8'($urandom_range(255));
          if (render_safe(rx, ry)) begin
            send_word(make_render(rx, ry));
            sent++;
          end else begin
            fill_and_render(rx, ry);
            sent += 4;
          end
        end
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_LCD_CONTROL;
    cfg_data  = '0;
    pix_stall = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_forwarding();
    test_tile_addressing();
    test_scroll_wrap();
    test_lcd_modes();
    test_random_traffic(11, 1'b0);
    test_random_traffic(2, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
